// ----- design/sha256_byte_stream_hasher_top_macros.svh -----
// assertion shorthands used by the top-level design file
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- design/sha256bsh_pkg.sv -----
package sha256bsh_pkg;

   // request modes
   localparam logic MODE_ABSORB = 1'b0;
   localparam logic MODE_FINISH = 1'b1;

   // eight 32-bit hash words, element 0 is word a / H0
   typedef logic [7:0][31:0] word8_type;

   // control from the sequencer to the round datapath
   typedef struct packed {
      logic       push;       // shift one message byte into the window
      logic [7:0] push_byte;
      logic       load;       // copy chaining hash into working vars
      logic       sched;      // compute next schedule word
      logic       do_round;   // apply one compression round
      logic [5:0] t;          // round number
   } rctl_type;

endpackage

// ----- design/sha256bsh_intf.sv -----
// request channel: one byte or a finish command per word
interface sha256bsh_req_intf;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink (input valid, input mode, input data_byte, output ready);
endinterface

// response channel: one digest word per word
interface sha256bsh_rsp_intf;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last;

   modport source (output valid, output digest_word, output word_index, output last,
                   input ready);
   modport sink (input valid, input digest_word, input word_index, input last,
                 output ready);
endinterface

// ----- design/sha256bsh_core.sv -----
module sha256bsh_core (
   input  logic                   clock,
   input  sha256bsh_pkg::rctl_type ctl,
   input  sha256bsh_pkg::word8_type hash,
   output sha256bsh_pkg::word8_type wv
);

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
      32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
      32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
      32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
      32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
      32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
      32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
      32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
      32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   // window: element 15 is the oldest word, element 0 the newest
   logic [15:0][31:0] win_ff, win_in;
   logic [511:0]      win_flat;
   logic [31:0]       w_ff, w_in;
   sha256bsh_pkg::word8_type wv_ff, wv_in;

   logic [31:0] w16, w15, w7, w2, ssig0, ssig1;
   logic [31:0] a, b, c, d, e, f, g, h;
   logic [31:0] bsig0, bsig1, ch, maj, t1, t2;

   assign win_flat = win_ff;

   // schedule taps at fixed window positions
   assign w16   = win_ff[15];
   assign w15   = win_ff[14];
   assign w7    = win_ff[6];
   assign w2    = win_ff[1];
   assign ssig0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
   assign ssig1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);

   // round terms
   assign a     = wv_ff[0];
   assign b     = wv_ff[1];
   assign c     = wv_ff[2];
   assign d     = wv_ff[3];
   assign e     = wv_ff[4];
   assign f     = wv_ff[5];
   assign g     = wv_ff[6];
   assign h     = wv_ff[7];
   assign bsig0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
   assign bsig1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
   assign ch    = g ^ (e & (f ^ g));
   assign maj   = (a & b) | (c & (a | b));
   assign t1    = h + bsig1 + ch + ROUND_K[ctl.t] + w_ff;
   assign t2    = bsig0 + maj;

   // window and schedule word update
   always_comb begin
      win_in = win_ff;
      w_in   = w_ff;
      if (ctl.push) begin
         win_in = {win_flat[503:0], ctl.push_byte};
      end else if (ctl.sched) begin
         if (ctl.t[5:4] == 2'b00) begin
            w_in = w16;
         end else begin
            w_in = ssig1 + w7 + ssig0 + w16;
         end
         win_in = {win_ff[14:0], w_in};
      end
   end

   // working variables: load or one round
   always_comb begin
      wv_in = wv_ff;
      if (ctl.load) begin
         wv_in = hash;
      end else if (ctl.do_round) begin
         wv_in[7] = g;
         wv_in[6] = f;
         wv_in[5] = e;
         wv_in[4] = d + t1;
         wv_in[3] = c;
         wv_in[2] = b;
         wv_in[1] = a;
         wv_in[0] = t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      w_ff   <= w_in;
      wv_ff  <= wv_in;
   end

   assign wv = wv_ff;

endmodule

// ----- design/sha256_byte_stream_hasher_top.sv -----
// SHA-256 hasher fed one message byte per request word. A request with mode 0
// absorbs data_byte and is taken whenever the hasher is idle; when it completes a
// 64-byte block the hasher is busy (64 rounds, each a schedule step and a round
// step on the one shared round unit, then the add into the chaining hash) before
// ready rises again. A request with mode 1 finishes the message: padding bytes
// (9 to 72 of them) are pushed one per cycle, paused while a full block is
// compressed as above; the padding fills one or two blocks, and then the eight
// digest words leave on the response channel, word 0 first, one per cycle as
// they are taken, last set on word 7. After the last word the hasher starts over
// with a new message. Ready is low whenever the block is busy.
`include "sha256_byte_stream_hasher_top_macros.svh"

module sha256_byte_stream_hasher_top (
   input  logic                     clock,
   input  logic                     reset,
   sha256bsh_req_intf.sink          req_ch,
   sha256bsh_rsp_intf.source        rsp_ch
);

   localparam logic [31:0] IV_WORDS [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };
   localparam logic [7:0] PAD_MARK    = 8'h80;
   localparam logic [5:0] FILL_LEN    = 6'd56;
   localparam logic [5:0] FILL_LAST   = 6'd63;
   localparam logic [5:0] ROUND_LAST  = 6'd63;
   localparam logic [3:0] LEN_BYTES   = 4'd8;
   localparam logic [2:0] WORD_LAST   = 3'd7;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PAD   = 6'b000010,
      ST_SCHED = 6'b000100,
      ST_ROUND = 6'b001000,
      ST_FOLD  = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type                 state_ff, state_in;
   logic [60:0]               count_ff, count_in;
   sha256bsh_pkg::word8_type  hash_ff, hash_in;
   logic [5:0]                t_ff, t_in;
   logic                      fin_ff, fin_in;
   logic                      mark_ff, mark_in;
   logic [3:0]                len_cnt_ff, len_cnt_in;
   logic [63:0]               len_ff, len_in;
   logic [2:0]                idx_ff, idx_in;

   sha256bsh_pkg::rctl_type   ctl;
   sha256bsh_pkg::word8_type  wv;
   logic [5:0]                fill;
   logic                      len_phase;
   logic [7:0]                pad_byte;
   logic                      last_round;
   logic                      last_taken;
   logic                      restarted;

   sha256bsh_core u_core (
      .clock (clock),
      .ctl   (ctl),
      .hash  (hash_ff),
      .wv    (wv)
   );

   // padding byte selection
   assign fill      = count_ff[5:0];
   assign len_phase = !mark_ff && ((len_cnt_ff != 4'd0) || (fill == FILL_LEN));
   always_comb begin
      if (mark_ff) begin
         pad_byte = PAD_MARK;
      end else if (len_phase) begin
         pad_byte = len_ff[63:56];
      end else begin
         pad_byte = 8'h00;
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      hash_in    = hash_ff;
      t_in       = t_ff;
      fin_in     = fin_ff;
      mark_in    = mark_ff;
      len_cnt_in = len_cnt_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      ctl        = '0;
      ctl.t      = t_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.mode == sha256bsh_pkg::MODE_ABSORB) begin
                  ctl.push      = 1'b1;
                  ctl.push_byte = req_ch.data_byte;
                  count_in      = count_ff + 61'd1;
                  if (fill == FILL_LAST) begin
                     ctl.load = 1'b1;
                     t_in     = 6'd0;
                     state_in = ST_SCHED;
                  end
               end else begin
                  len_in     = {count_ff, 3'b000};
                  fin_in     = 1'b1;
                  mark_in    = 1'b1;
                  len_cnt_in = 4'd0;
                  state_in   = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            ctl.push      = 1'b1;
            ctl.push_byte = pad_byte;
            count_in      = count_ff + 61'd1;
            mark_in       = 1'b0;
            if (len_phase) begin
               len_in     = {len_ff[55:0], 8'h00};
               len_cnt_in = len_cnt_ff + 4'd1;
            end
            if (fill == FILL_LAST) begin
               ctl.load = 1'b1;
               t_in     = 6'd0;
               state_in = ST_SCHED;
            end
         end
         ST_SCHED: begin
            ctl.sched = 1'b1;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            ctl.do_round = 1'b1;
            t_in         = t_ff + 6'd1;
            state_in     = (t_ff == ROUND_LAST) ? ST_FOLD : ST_SCHED;
         end
         ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + wv[i];
            end
            if (len_cnt_ff == LEN_BYTES) begin
               idx_in   = 3'd0;
               state_in = ST_EMIT;
            end else if (fin_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            // shift the digest out and the initial values in behind it
            if (rsp_ch.ready) begin
               for (int i = 0; i < 7; i++) begin
                  hash_in[i] = hash_ff[i + 1];
               end
               hash_in[7] = IV_WORDS[idx_ff];
               idx_in     = idx_ff + 3'd1;
               if (idx_ff == WORD_LAST) begin
                  count_in   = '0;
                  fin_in     = 1'b0;
                  len_cnt_in = 4'd0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         fin_ff     <= 1'b0;
         mark_ff    <= 1'b0;
         len_cnt_ff <= 4'd0;
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= IV_WORDS[i];
         end
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         fin_ff     <= fin_in;
         mark_ff    <= mark_in;
         len_cnt_ff <= len_cnt_in;
         hash_ff    <= hash_in;
      end
   end

   // datapath registers without reset
   always_ff @(posedge clock) begin
      t_ff   <= t_in;
      len_ff <= len_in;
      idx_ff <= idx_in;
   end

   // channel outputs
   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = (state_ff == ST_EMIT);
   assign rsp_ch.digest_word = hash_ff[0];
   assign rsp_ch.word_index  = idx_ff;
   assign rsp_ch.last        = (idx_ff == WORD_LAST);

   // terms for the checks
   assign last_round = (state_ff == ST_ROUND) && (t_ff == ROUND_LAST);
   assign last_taken = rsp_ch.valid && rsp_ch.ready && rsp_ch.last;
   assign restarted  = (hash_ff[0] == IV_WORDS[0]) && (count_ff == '0);

   // checks
   `ASSERT_SAME(a_no_overlap, rsp_ch.valid, !req_ch.ready, "digest out while taking requests")
   `ASSERT_SAME(a_emit_padded, rsp_ch.valid, len_cnt_ff == LEN_BYTES, "digest before length")
   `ASSERT_NEXT(a_fold_after_last, last_round, state_ff == ST_FOLD, "no fold after last round")
   `ASSERT_NEXT(a_iv_restored, last_taken, restarted, "hash not restarted")

endmodule
